[design/fft_bin_polar_relative_top_defines.svh]
// Assertion macros shared by the design files.
// No dependencies.
`ifndef FFT_BIN_POLAR_RELATIVE_TOP_DEFINES_SVH
`define FFT_BIN_POLAR_RELATIVE_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FBP_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FBP_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[design/fbp_pkg.sv]
// Package for the FFT bin polar converter: types, constants, CORDIC table.
// No dependencies.
package fbp_pkg;
    localparam int unsigned CordicSteps = 30;
    localparam logic [13:0] RelScale = 14'd10000;

    typedef enum logic [1:0] {
        OP_SQRT,
        OP_CORDIC,
        OP_DIV
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_SQRT_W,
        ST_DIVDC,
        ST_DIVDC_W,
        ST_CORD,
        ST_CORD_W,
        ST_DIV,
        ST_DIV_W,
        ST_OUT0,
        ST_OUT1
    } t_state;

    typedef struct packed {
        logic        start;
        t_op         op;
    } t_unit_cmd;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction
endpackage

[design/fbp_unit.sv]
// Shared iterative unit: integer square root, CORDIC vectoring, restoring division.
// Depends on fbp_pkg and the assertion header.
`include "fft_bin_polar_relative_top_defines.svh"
module fbp_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fbp_pkg::t_unit_cmd i_cmd,
    input  logic signed [23:0] i_re,
    input  logic signed [23:0] i_im,
    input  logic [23:0]       i_num,
    input  logic [23:0]       i_den,
    output logic              o_done,
    output logic [23:0]       o_mag,
    output logic [15:0]       o_phase,
    output logic [31:0]       o_quot
);
    localparam logic [13:0] RelScaleW = fbp_pkg::RelScale;

    // Working registers; r_busy, r_op and r_cnt serve every operation, r_a and r_b serve sqrt and division.
    logic              r_busy, n_busy;
    fbp_pkg::t_op      r_op, n_op;
    logic [5:0]        r_cnt, n_cnt;
    logic [47:0]       r_a, n_a;     // sqrt remainder / division remainder
    logic [47:0]       r_b, n_b;     // sqrt input / division dividend
    logic [24:0]       r_r, n_r;     // sqrt root
    logic signed [45:0] r_x, n_x;
    logic signed [45:0] r_y, n_y;
    logic [31:0]       r_ang, n_ang;
    logic [37:0]       r_q, n_q;
    logic              r_zero, n_zero;
    logic              r_done, n_done;
    logic [23:0]       r_den;

    logic [49:0] trial;
    logic [49:0] rem2;
    logic [24:0] dsub;
    logic [47:0] sq_re, sq_im;
    logic signed [45:0] sx, sy;
    logic [47:0] ph_prod;
    logic [47:0] ph_full;

    assign sq_re = 48'($signed(i_re) * $signed(i_re));
    assign sq_im = 48'($signed(i_im) * $signed(i_im));
    assign ph_prod = 48'(r_ang[31:16]) * 48'd36000;

    always_comb begin
        n_busy = r_busy; n_op = r_op; n_cnt = r_cnt; n_a = r_a; n_b = r_b;
        n_r = r_r; n_x = r_x; n_y = r_y; n_ang = r_ang; n_q = r_q;
        n_zero = r_zero; n_done = 1'b0;
        trial = '0; rem2 = '0; dsub = '0;
        sx = r_x >>> r_cnt[4:0];
        sy = r_y >>> r_cnt[4:0];
        if (i_cmd.start && !r_busy) begin
            n_busy = 1'b1; n_op = i_cmd.op; n_cnt = '0;
            unique case (i_cmd.op)
                fbp_pkg::OP_SQRT: begin
                    n_b = sq_re + sq_im; n_a = '0; n_r = '0;
                end
                fbp_pkg::OP_CORDIC: begin
                    n_zero = (i_re == 24'sd0) && (i_im == 24'sd0);
                    if (i_re < 0) begin
                        n_x = -(46'(i_re) <<< 20); n_y = -(46'(i_im) <<< 20);
                        n_ang = 32'h80000000;
                    end else begin
                        n_x = 46'(i_re) <<< 20; n_y = 46'(i_im) <<< 20;
                        n_ang = '0;
                    end
                end
                default: begin
                    // Dividend num*10000 + den/2, 38 quotient bits.
                    n_b = 48'(i_num) * 48'(RelScaleW) + 48'(i_den >> 1);
                    n_a = '0; n_q = '0;
                end
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt + 6'd1;
            unique case (r_op)
                fbp_pkg::OP_SQRT: begin
                    // Digit-by-digit root, two input bits a step, 24 steps.
                    rem2 = {r_a[47:0], r_b[47:46]};
                    trial = {23'd0, r_r, 2'b01};
                    n_b = r_b << 2;
                    if (rem2 >= trial) begin
                        n_a = 48'(rem2 - trial); n_r = {r_r[23:0], 1'b1};
                    end else begin
                        n_a = rem2[47:0]; n_r = {r_r[23:0], 1'b0};
                    end
                    if (r_cnt == 6'd23) begin
                        n_busy = 1'b0; n_done = 1'b1;
                        // Round up when remainder exceeds root.
                        if (n_a > 48'(n_r)) n_r = n_r + 25'd1;
                    end
                end
                fbp_pkg::OP_CORDIC: begin
                    if (r_cnt < 6'(fbp_pkg::CordicSteps)) begin
                        if (r_y >= 0) begin
                            n_x = r_x + sy; n_y = r_y - sx;
                            n_ang = r_ang + fbp_pkg::atan_turn(r_cnt[4:0]);
                        end else begin
                            n_x = r_x - sy; n_y = r_y + sx;
                            n_ang = r_ang - fbp_pkg::atan_turn(r_cnt[4:0]);
                        end
                    end else begin
                        n_busy = 1'b0; n_done = 1'b1;
                    end
                end
                default: begin
                    dsub = 25'({r_a[23:0], r_b[37]}) - 25'({1'b0, r_den});
                    n_b = r_b << 1;
                    if ({r_a[23:0], r_b[37]} >= {1'b0, r_den}) begin
                        n_a = 48'(dsub[23:0]); n_q = {r_q[36:0], 1'b1};
                    end else begin
                        n_a = 48'({r_a[22:0], r_b[37]}); n_q = {r_q[36:0], 1'b0};
                    end
                    if (r_cnt == 6'd37) begin
                        n_busy = 1'b0; n_done = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_op <= fbp_pkg::OP_SQRT;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_op <= n_op;
        end
        r_cnt <= n_cnt; r_a <= n_a; r_b <= n_b; r_r <= n_r; r_x <= n_x; r_y <= n_y;
        r_ang <= n_ang; r_q <= n_q; r_zero <= n_zero;
        if (i_cmd.start && !r_busy) r_den <= i_den;
    end

    // 32x16 product angle*36000 over 2^16: the low half's product is shifted down before it is added, then rounded.
    assign ph_full = ph_prod + 48'((48'(r_ang[15:0]) * 48'd36000) >> 16) + 48'h8000;

    always_comb begin
        o_done = r_done;
        o_mag = r_r[23:0];
        if (r_zero || ph_full[47:16] >= 32'd36000) o_phase = '0;
        else o_phase = ph_full[31:16];
        if (r_den == 24'd0) o_quot = '1;
        else if (r_q[37:32] != 6'd0) o_quot = '1;
        else o_quot = r_q[31:0];
    end

    `FBP_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_cmd.start && !r_busy, r_busy)
    `FBP_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `FBP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_busy, r_cnt <= 6'd37)
endmodule

[design/fft_bin_polar_relative_top.sv]
// Top level: sequencer around one shared sqrt / CORDIC / divide unit.
// Every bin runs the square root; bin 1 then runs the DC division and CORDIC, bin 2 and
// up run CORDIC and division, before the results are offered. A DC bin or an ignored
// bin gives no result and frees the input after the square root. A new bin is accepted
// only once the last one is through; the shared unit iterates 24, 30 and 38 steps.
// Reset (synchronous, active low) clears the spectrum state and the sequencer.
`include "fft_bin_polar_relative_top_defines.svh"
module fft_bin_polar_relative_top #(
    parameter int unsigned MAX_BINS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // re_part[23:0], im_part[47:24]
    input  logic        s_axis_tuser,  // first_bin
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // bin_index, magnitude, relative_value, phase_angle
    output logic        m_axis_tlast   // last_of_item
);
    localparam int unsigned CntW = $clog2(MAX_BINS + 1);

    fbp_pkg::t_state r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_act, n_act;
    logic [23:0]     r_dcmag, r_fund, r_mag;
    logic [23:0]     r_re, r_im;
    logic [31:0]     r_dcrel, r_rel;
    logic [15:0]     r_ph;
    logic [CntW-1:0] r_idx;
    logic            r_first;
    fbp_pkg::t_unit_cmd cmd;
    logic [23:0] num, den;
    logic        u_done;
    logic [23:0] u_mag;
    logic [15:0] u_ph;
    logic [31:0] u_q;
    logic        acc;

    assign acc = s_axis_tvalid && s_axis_tready;

    fbp_unit u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_re(r_re), .i_im(r_im), .i_num(num), .i_den(den),
        .o_done(u_done), .o_mag(u_mag), .o_phase(u_ph), .o_quot(u_q)
    );

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_act = r_act;
        cmd.start = 1'b0; cmd.op = fbp_pkg::OP_SQRT;
        num = r_mag; den = r_fund;
        s_axis_tready = (r_state == fbp_pkg::ST_IDLE);
        m_axis_tvalid = 1'b0; m_axis_tlast = 1'b0;
        m_axis_tdata = {16'(r_ph), r_rel, r_mag, 8'(r_idx)};
        unique case (r_state)
            fbp_pkg::ST_IDLE: if (acc) n_state = fbp_pkg::ST_SQRT;
            fbp_pkg::ST_SQRT: begin
                cmd.start = 1'b1; n_state = fbp_pkg::ST_SQRT_W;
            end
            fbp_pkg::ST_SQRT_W: if (u_done) begin
                if (r_first) begin
                    n_state = fbp_pkg::ST_IDLE; n_act = 1'b1; n_cnt = CntW'(1);
                end else if (!r_act || r_cnt >= CntW'(MAX_BINS)) begin
                    n_state = fbp_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + CntW'(1);
                    n_state = (r_cnt == CntW'(1)) ? fbp_pkg::ST_DIVDC : fbp_pkg::ST_CORD;
                end
            end
            fbp_pkg::ST_DIVDC: begin
                cmd.start = 1'b1; cmd.op = fbp_pkg::OP_DIV;
                num = r_dcmag; den = r_mag; n_state = fbp_pkg::ST_DIVDC_W;
            end
            fbp_pkg::ST_DIVDC_W: if (u_done) n_state = fbp_pkg::ST_CORD;
            fbp_pkg::ST_CORD: begin
                cmd.start = 1'b1; cmd.op = fbp_pkg::OP_CORDIC;
                n_state = fbp_pkg::ST_CORD_W;
            end
            fbp_pkg::ST_CORD_W: if (u_done)
                n_state = (r_idx == CntW'(1)) ? fbp_pkg::ST_OUT0 : fbp_pkg::ST_DIV;
            fbp_pkg::ST_DIV: begin
                cmd.start = 1'b1; cmd.op = fbp_pkg::OP_DIV;
                n_state = fbp_pkg::ST_DIV_W;
            end
            fbp_pkg::ST_DIV_W: if (u_done) n_state = fbp_pkg::ST_OUT1;
            fbp_pkg::ST_OUT0: begin
                m_axis_tvalid = 1'b1;
                m_axis_tdata = {16'd0, r_dcrel, r_dcmag, 8'd0};
                if (m_axis_tready) n_state = fbp_pkg::ST_OUT1;
            end
            fbp_pkg::ST_OUT1: begin
                m_axis_tvalid = 1'b1; m_axis_tlast = 1'b1;
                if (m_axis_tready) n_state = fbp_pkg::ST_IDLE;
            end
            default: n_state = fbp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbp_pkg::ST_IDLE; r_cnt <= '0; r_act <= 1'b0;
            r_dcmag <= '0; r_fund <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_act <= n_act;
            if (r_state == fbp_pkg::ST_SQRT_W && u_done) begin
                if (r_first) r_dcmag <= u_mag;
                else if (r_act && r_cnt == CntW'(1)) r_fund <= u_mag;
            end
        end
        if (acc) begin
            r_re <= s_axis_tdata[23:0]; r_im <= s_axis_tdata[47:24];
            r_first <= s_axis_tuser;
        end
        if (r_state == fbp_pkg::ST_SQRT_W && u_done) begin
            r_mag <= u_mag; r_idx <= r_cnt; r_rel <= 32'(u_mag);
        end
        if (r_state == fbp_pkg::ST_DIVDC_W && u_done)
            r_dcrel <= (r_mag == 24'd0 && r_dcmag == 24'd0) ? 32'd0 : u_q;
        if (r_state == fbp_pkg::ST_DIV_W && u_done)
            r_rel <= (r_fund == 24'd0 && r_mag == 24'd0) ? 32'd0 : u_q;
        if (r_state == fbp_pkg::ST_CORD_W && u_done) r_ph <= u_ph;
    end

    `FBP_ASSERT_IMP(a_no_rdy_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `FBP_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CntW'(MAX_BINS))
    `FBP_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, acc, !s_axis_tready)
endmodule

[test/tb_fft_bin_polar_relative_top.sv]
// Testbench for fft_bin_polar_relative_top: drives FFT bins in as spectra and checks
// each result against an in-bench predictor of magnitude, phase and relative value.
// Depends on the fft_bin_polar_relative_top RTL only.
`timescale 1ns / 100ps

class bin_result_scoreboard;
    typedef struct packed {
        logic [7:0]  idx;
        logic [23:0] mag;
        logic [31:0] rel;
        logic [15:0] ph;
        logic        last;
    } t_bin_result;

    t_bin_result pending_results[$];
    int          errors;
    int unsigned next_bin;
    logic [23:0] held_dc_mag;
    logic [23:0] fund_mag;
    bit          spectrum_on;
    int unsigned max_bins;

    function new(int unsigned mb);
        max_bins    = mb;
        errors      = 0;
        next_bin    = 0;
        held_dc_mag = '0;
        fund_mag    = '0;
        spectrum_on = 0;
    endfunction

    function logic [23:0] isqrt_round(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 46;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (s > r) r++;
        return r[23:0];
    endfunction

    function logic [31:0] atan_step(int i);
        logic [31:0] t[30] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001};
        return t[i];
    endfunction

    function logic [15:0] phase_centideg(logic signed [63:0] re, logic signed [63:0] im);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [31:0] ang;
        logic [63:0] p;
        if (re == 0 && im == 0) return 16'd0;
        x = re <<< 20;
        y = im <<< 20;
        ang = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            ang = 32'h80000000;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += atan_step(i);
            end else begin
                x -= dx; y += dy; ang -= atan_step(i);
            end
        end
        p = (64'(ang) * 64'd36000 + 64'h80000000) >> 32;
        if (p >= 36000) p = 0;
        return p[15:0];
    endfunction

    function logic [31:0] rel_to_fund(logic [23:0] m, logic [23:0] f);
        logic [63:0] q;
        if (f == 0) return (m == 0) ? 32'd0 : 32'hFFFFFFFF;
        q = (64'(m) * 64'd10000 + 64'(f >> 1)) / 64'(f);
        return (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    endfunction

    // Notes one accepted bin and queues the results it causes.
    function void note_bin(logic signed [23:0] re, logic signed [23:0] im, logic first);
        logic signed [63:0] r64;
        logic signed [63:0] i64;
        logic [23:0] m;
        int unsigned k;
        r64 = re;
        i64 = im;
        m = isqrt_round(64'(r64 * r64) + 64'(i64 * i64));
        if (first) begin
            next_bin = 1;
            held_dc_mag = m;
            spectrum_on = 1;
            return;
        end
        if (!spectrum_on || next_bin >= max_bins) return;
        k = next_bin;
        next_bin++;
        if (k == 1) begin
            fund_mag = m;
            pending_results.push_back({8'd0, held_dc_mag, rel_to_fund(held_dc_mag, m),
                                       16'd0, 1'b0});
            pending_results.push_back({8'd1, m, 8'd0, m, phase_centideg(r64, i64), 1'b1});
        end else begin
            pending_results.push_back({k[7:0], m, rel_to_fund(m, fund_mag),
                                       phase_centideg(r64, i64), 1'b1});
        end
    endfunction

    function void check_result(logic [79:0] data, logic last);
        t_bin_result e;
        t_bin_result a;
        a = {data[7:0], data[31:8], data[63:32], data[79:64], last};
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, a);
            errors++;
            return;
        end
        e = pending_results.pop_front();
        if (a !== e) begin
            $display("%0t: mismatch, expected idx=%0d mag=%0d rel=%0d ph=%0d last=%0d",
                     $time, e.idx, e.mag, e.rel, e.ph, e.last);
            $display("%0t:           actual idx=%0d mag=%0d rel=%0d ph=%0d last=%0d",
                     $time, a.idx, a.mag, a.rel, a.ph, a.last);
            errors++;
        end
    endfunction
endclass

module tb_fft_bin_polar_relative_top;
    localparam int unsigned MaxBins = 256;
    localparam int unsigned CycleLimit = 2_000_000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // re_part[23:0], im_part[47:24]
    logic        s_axis_tuser = 0;    // first_bin
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [79:0] m_axis_tdata;        // bin_index, magnitude, relative_value, phase_angle
    logic        m_axis_tlast;        // last_of_item

    bin_result_scoreboard sb = new(MaxBins);
    int unsigned cycles = 0;
    bit          long_hold = 0;

    fft_bin_polar_relative_top #(.MAX_BINS(MaxBins)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("fft_bin_polar_relative_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_bin(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tuser);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Receiver stalls on its own pattern; a long hold-off is requested separately.
    initial begin
        int unsigned phase;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (long_hold)
                m_axis_tready <= 0;
            else if ((phase / 200) % 3 == 0)
                m_axis_tready <= 1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Valid stays high after the transaction so that bins can follow back to back.
    task automatic send_bin(logic [23:0] re, logic [23:0] im, logic first);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {im, re};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'(32'($urandom_range(0, 40)) - 20);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic burst_gap();
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    task automatic send_spectrum(int unsigned nbins);
        send_bin(rand_field(), rand_field(), 1);
        for (int unsigned b = 1; b < nbins; b++) begin
            burst_gap();
            send_bin(rand_field(), rand_field(), 0);
        end
    endtask

    initial begin
        int unsigned sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: stray bin with no spectrum, single-bin spectrum, extremes, zero vectors.
        send_bin(24'd5, 24'd5, 0);
        send_bin(24'd100, 24'd0, 1);
        send_bin(24'd3, 24'd4, 1);
        send_bin(24'd0, 24'd0, 0);             // zero fundamental
        send_bin(24'd0, 24'd0, 0);
        send_bin(24'h7FFFFF, 24'h800000, 0);   // saturates against zero fundamental
        send_bin(24'h800000, 24'h800000, 1);
        send_bin(24'd1, 24'd0, 0);             // tiny fundamental, big DC overflows
        send_bin(24'h7FFFFF, 24'h7FFFFF, 0);
        send_bin(24'h800000, 24'd0, 0);
        send_bin(24'd0, 24'h800000, 0);
        send_bin(24'hFFFFFF, 24'd0, 0);
        send_bin(24'd0, 24'hFFFFFF, 0);
        send_bin(24'hFFFFFF, 24'hFFFFFF, 0);
        send_bin(24'd7, 24'd0, 1);             // DC dropped by the next first bin
        // Long spectrum runs past the bin limit.
        send_spectrum(MaxBins + 4);
        // Pressure: receiver holds off while input keeps coming.
        fork
            begin
                long_hold = 1;
                repeat (2000) @(posedge i_clk);
                long_hold = 0;
            end
            send_spectrum(12);
        join
        // Count the directed bins so the whole run stays near 600 bins.
        sent = 15 + MaxBins + 4 + 12;
        while (sent < 600) begin
            int unsigned n;
            case ($urandom_range(0, 9))
                0: n = 1;
                1: n = $urandom_range(2, 3);
                default: n = $urandom_range(2, 16);
            endcase
            if ($urandom_range(0, 15) == 0) begin
                send_bin(rand_field(), rand_field(), 0);
                sent++;
            end
            send_spectrum(n);
            sent += n;
        end
        s_axis_tvalid <= 0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("fft_bin_polar_relative_top regression: pass");
        else
            $display("fft_bin_polar_relative_top regression: fail");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/fbp_pkg.sv
design/fbp_unit.sv
design/fft_bin_polar_relative_top.sv
test/tb_fft_bin_polar_relative_top.sv
